// ----- hdl/ietb_pkg.sv -----
// Shared request codes and the trace ring entry layout for the event trace buffer.
package ietb_pkg;

  localparam int unsigned CountW = 48;
  localparam int unsigned AddrW  = 20;
  localparam int unsigned DataW  = 16;
  localparam int unsigned KindW  = 3;

  // Request mode codes
  localparam logic [3:0] MODE_WR_WORD  = 4'd0;
  localparam logic [3:0] MODE_RD_WORD  = 4'd1;
  localparam logic [3:0] MODE_WR_BYTE  = 4'd2;
  localparam logic [3:0] MODE_RD_BYTE  = 4'd3;
  localparam logic [3:0] MODE_IRQ_ACK  = 4'd4;
  localparam logic [3:0] MODE_RESET    = 4'd5;
  localparam logic [3:0] MODE_STEP     = 4'd6;
  localparam logic [3:0] MODE_TRIGGER  = 4'd7;
  localparam logic [3:0] MODE_UNTRIG   = 4'd8;
  localparam logic [3:0] MODE_CLEAR    = 4'd9;
  localparam logic [3:0] MODE_READBACK = 4'd10;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [AddrW-1:0]  addr;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] stamp;
  } log_entry_t;

endpackage

// ----- hdl/ietb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ietb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/io_event_trace_buffer.sv -----
// Top level of the event trace buffer: request decode, ring pointers, counters, results.
//
// Usage: one request is taken on every clock where start is high; busy never
// rises. Each request gives exactly one result, shown for one cycle with done_o
// high in the cycle right after acceptance, so the block sustains one request per
// clock. The figure is set by the single state update between the request and the
// result register, plus the ring RAM's registered read port, which delivers the
// read-back entry in that same following cycle. Results cannot be held off: the
// receiver must take each one while done_o is high. Counters and the IRQ state on
// the result ports hold their value until the next request is accepted. The ring
// stores DEPTH entries and keeps at most DEPTH-1 events; logging into a full ring
// drops the oldest. No clearing pass is needed after reset: slots are only read
// back below the fill count, so never-written slots are never visible.
module io_event_trace_buffer #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode_i,
  input  logic [19:0] addr_i,
  input  logic [15:0] data_i,
  input  logic [3:0]  irq_i,
  input  logic [7:0]  mclk_ticks_i,
  input  logic [7:0]  smclk_ticks_i,
  input  logic [7:0]  aclk_ticks_i,
  input  logic        cpu_off_i,
  input  logic [3:0]  entry_index_i,
  output logic        done_o,
  output logic        irq_pending_o,
  output logic [3:0]  irq_number_o,
  output logic        entry_valid_o,
  output logic [2:0]  entry_kind_o,
  output logic [47:0] entry_time_o,
  output logic [19:0] entry_addr_o,
  output logic [15:0] entry_data_o,
  output logic [3:0]  fill_count_o,
  output logic [47:0] instr_count_o,
  output logic [47:0] mclk_count_o,
  output logic [47:0] smclk_count_o,
  output logic [47:0] aclk_count_o
);

  import ietb_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  // Wide enough for a fill count, a 4-bit index and their sum below 2*DEPTH.
  localparam int unsigned CalcW = (PtrW + 1 > 5) ? PtrW + 1 : 5;
  localparam int unsigned EntryW = $bits(log_entry_t);

  // Ring increment, wrapping at DEPTH (not necessarily a power of two).
  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (CalcW'(p) == CalcW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  logic                 accept;
  logic                 done_q;

  logic [PtrW-1:0]      wptr_q, wptr_d;
  logic [PtrW-1:0]      optr_q, optr_d;
  logic [CountW-1:0]    main_q, main_d;
  logic [CountW-1:0]    sub_q, sub_d;
  logic [CountW-1:0]    aux_q, aux_d;
  logic [CountW-1:0]    instr_q, instr_d;
  logic                 req_valid_q, req_valid_d;
  logic [3:0]           req_num_q, req_num_d;
  logic                 rb_valid_q, rb_valid_d;

  logic                 log_we;
  log_entry_t           log_wr;
  log_entry_t           log_rd;
  logic [EntryW-1:0]    rd_raw;
  logic [PtrW-1:0]      wptr_inc;

  logic [CalcW-1:0]     fill_cur;   // fill count of the current ring state
  logic [CalcW-1:0]     fill_out;   // fill count after the last request
  logic [CalcW-1:0]     slot_sum;
  logic [PtrW-1:0]      rd_slot;

  assign busy   = 1'b0;
  assign accept = start;

  // Fill = (wptr - optr) mod DEPTH
  always_comb begin
    if (wptr_q >= optr_q) begin
      fill_cur = CalcW'(wptr_q) - CalcW'(optr_q);
    end else begin
      fill_cur = CalcW'(wptr_q) + CalcW'(DEPTH) - CalcW'(optr_q);
    end
  end
  assign fill_out = fill_cur;

  // Readback slot: oldest + index; the entry is valid only when the index is below the fill count.
  always_comb begin
    slot_sum = CalcW'(optr_q) + CalcW'(entry_index_i);
    if (slot_sum >= CalcW'(DEPTH)) begin
      slot_sum = slot_sum - CalcW'(DEPTH);
    end
    rd_slot = slot_sum[PtrW-1:0];
  end

  assign wptr_inc = ptr_next(wptr_q);

  // Request decode and next state
  always_comb begin
    wptr_d      = wptr_q;
    optr_d      = optr_q;
    main_d      = main_q;
    sub_d       = sub_q;
    aux_d       = aux_q;
    instr_d     = instr_q;
    req_valid_d = req_valid_q;
    req_num_d   = req_num_q;
    rb_valid_d  = 1'b0;
    log_we      = 1'b0;
    log_wr.kind  = mode_i[KindW-1:0];
    log_wr.addr  = addr_i;
    log_wr.data  = '0;
    log_wr.stamp = main_q;

    unique case (mode_i)
      MODE_WR_WORD: begin
        log_we      = 1'b1;
        log_wr.data = data_i;
      end
      MODE_WR_BYTE: begin
        log_we      = 1'b1;
        log_wr.data = {8'h00, data_i[7:0]};
      end
      MODE_RD_WORD, MODE_RD_BYTE: begin
        log_we = 1'b1;
      end
      MODE_IRQ_ACK: begin
        log_we      = 1'b1;
        log_wr.addr = AddrW'(irq_i);
        if (req_valid_q && (req_num_q == irq_i)) begin
          req_valid_d = 1'b0;
        end
      end
      MODE_RESET: begin
        log_we      = 1'b1;
        log_wr.addr = '0;
      end
      MODE_STEP: begin
        main_d = main_q + CountW'(mclk_ticks_i);
        sub_d  = sub_q + CountW'(smclk_ticks_i);
        aux_d  = aux_q + CountW'(aclk_ticks_i);
        if (!cpu_off_i) begin
          instr_d = instr_q + CountW'(1);
        end
      end
      MODE_TRIGGER: begin
        req_valid_d = 1'b1;
        req_num_d   = irq_i;
      end
      MODE_UNTRIG: begin
        req_valid_d = 1'b0;
      end
      MODE_CLEAR: begin
        wptr_d  = '0;
        optr_d  = '0;
        main_d  = '0;
        sub_d   = '0;
        aux_d   = '0;
        instr_d = '0;
      end
      MODE_READBACK: begin
        rb_valid_d = CalcW'(entry_index_i) < fill_cur;
      end
      default: begin
        // unused codes only report
      end
    endcase

    if (log_we) begin
      wptr_d = wptr_inc;
      // full ring: drop the oldest event
      if (wptr_inc == optr_q) begin
        optr_d = ptr_next(optr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      wptr_q      <= '0;
      optr_q      <= '0;
      main_q      <= '0;
      sub_q       <= '0;
      aux_q       <= '0;
      instr_q     <= '0;
      req_valid_q <= 1'b0;
      req_num_q   <= '0;
      rb_valid_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        wptr_q      <= wptr_d;
        optr_q      <= optr_d;
        main_q      <= main_d;
        sub_q       <= sub_d;
        aux_q       <= aux_d;
        instr_q     <= instr_d;
        req_valid_q <= req_valid_d;
        req_num_q   <= req_num_d;
        rb_valid_q  <= rb_valid_d;
      end
    end
  end

  // Ring storage; the read port is addressed at acceptance so data lines up
  // with the result cycle.
  ietb_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && log_we),
    .waddr_i (wptr_q),
    .wdata_i (log_wr),
    .raddr_i (rd_slot),
    .rdata_o (rd_raw)
  );

  assign log_rd = log_entry_t'(rd_raw);

  // Results
  assign done_o        = done_q;
  assign irq_pending_o = req_valid_q;
  assign irq_number_o  = req_valid_q ? req_num_q : 4'd0;
  assign entry_valid_o = rb_valid_q;
  assign entry_kind_o  = rb_valid_q ? log_rd.kind  : '0;
  assign entry_time_o  = rb_valid_q ? log_rd.stamp : '0;
  assign entry_addr_o  = rb_valid_q ? log_rd.addr  : '0;
  assign entry_data_o  = rb_valid_q ? log_rd.data  : '0;
  assign fill_count_o  = fill_out[3:0];
  assign instr_count_o = instr_q;
  assign mclk_count_o  = main_q;
  assign smclk_count_o = sub_q;
  assign aclk_count_o  = aux_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for io_event_trace_buffer: directed and random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ietb_pkg::*;

  localparam int StallLimit = 2000;   // cycles with no request and no result
  localparam int RandomPerPhase = 500;

  typedef struct {
    logic [3:0]        mode;
    logic [AddrW-1:0]  addr;
    logic [DataW-1:0]  data;
    logic [3:0]        irq;
    logic [7:0]        mclk;
    logic [7:0]        smclk;
    logic [7:0]        aclk;
    logic              cpu_off;
    logic [3:0]        index;
  } trace_req_t;

  typedef struct {
    logic              irq_pending;
    logic [3:0]        irq_number;
    logic              entry_valid;
    logic [KindW-1:0]  entry_kind;
    logic [CountW-1:0] entry_time;
    logic [AddrW-1:0]  entry_addr;
    logic [DataW-1:0]  entry_data;
    logic [3:0]        fill_count;
    logic [CountW-1:0] instr_count;
    logic [CountW-1:0] mclk_count;
    logic [CountW-1:0] smclk_count;
    logic [CountW-1:0] aclk_count;
  } trace_res_t;

  // Shadow copy of the trace ring, counters and pending IRQ; one result per request.
  class trace_shadow;
    log_entry_t        ring[16];
    logic [3:0]        wr_ptr;
    logic [3:0]        old_ptr;    // 4-bit pointers wrap like the 16-slot ring
    logic [CountW-1:0] mclk_acc;
    logic [CountW-1:0] smclk_acc;
    logic [CountW-1:0] aclk_acc;
    logic [CountW-1:0] instr_acc;
    logic              pend_valid;
    logic [3:0]        pend_num;
    trace_res_t        expected_results[$];
    int                mismatches;
    int                requests;
    int                hits;
    int                drops;
    int                clears;

    function new();
      wr_ptr = '0;
      old_ptr = '0;
      mclk_acc = '0;
      smclk_acc = '0;
      aclk_acc = '0;
      instr_acc = '0;
      pend_valid = 1'b0;
      pend_num = '0;
      mismatches = 0;
      requests = 0;
      hits = 0;
      drops = 0;
      clears = 0;
    endfunction

    function logic [3:0] fill();
      return wr_ptr - old_ptr;
    endfunction

    function logic [3:0] pending_irq();
      return pend_num;
    endfunction

    function void log_event(logic [2:0] kind, logic [AddrW-1:0] addr, logic [DataW-1:0] data);
      ring[wr_ptr].kind  = kind;
      ring[wr_ptr].addr  = addr;
      ring[wr_ptr].data  = data;
      ring[wr_ptr].stamp = mclk_acc;
      wr_ptr++;
      // full ring: oldest event is dropped
      if (wr_ptr == old_ptr) begin
        old_ptr++;
        drops++;
      end
    endfunction

    function void take_request(trace_req_t r);
      trace_res_t res;
      logic [3:0] slot;
      requests++;
      case (r.mode)
        MODE_WR_WORD: log_event(r.mode[2:0], r.addr, r.data);
        MODE_RD_WORD: log_event(r.mode[2:0], r.addr, '0);
        MODE_WR_BYTE: log_event(r.mode[2:0], r.addr, {8'h00, r.data[7:0]});
        MODE_RD_BYTE: log_event(r.mode[2:0], r.addr, '0);
        MODE_IRQ_ACK: begin
          // only a matching ack retires the request, but every ack is logged
          if (pend_valid && pend_num == r.irq) pend_valid = 1'b0;
          log_event(r.mode[2:0], {16'h0000, r.irq}, '0);
        end
        MODE_RESET: log_event(r.mode[2:0], '0, '0);
        MODE_STEP: begin
          mclk_acc  = mclk_acc + r.mclk;
          smclk_acc = smclk_acc + r.smclk;
          aclk_acc  = aclk_acc + r.aclk;
          if (!r.cpu_off) instr_acc = instr_acc + 1;
        end
        MODE_TRIGGER: begin
          pend_valid = 1'b1;
          pend_num   = r.irq;
        end
        MODE_UNTRIG: pend_valid = 1'b0;
        MODE_CLEAR: begin
          // history and counters go, the pending request stays
          wr_ptr = '0;
          old_ptr = '0;
          mclk_acc = '0;
          smclk_acc = '0;
          aclk_acc = '0;
          instr_acc = '0;
          clears++;
        end
        default: ;
      endcase

      res = '{default: '0};
      if (r.mode == MODE_READBACK && r.index < fill()) begin
        slot = old_ptr + r.index;
        res.entry_valid = 1'b1;
        res.entry_kind  = ring[slot].kind;
        res.entry_time  = ring[slot].stamp;
        res.entry_addr  = ring[slot].addr;
        res.entry_data  = ring[slot].data;
        hits++;
      end
      res.irq_pending = pend_valid;
      res.irq_number  = pend_valid ? pend_num : 4'd0;
      res.fill_count  = fill();
      res.instr_count = instr_acc;
      res.mclk_count  = mclk_acc;
      res.smclk_count = smclk_acc;
      res.aclk_count  = aclk_acc;
      expected_results.push_back(res);
    endfunction

    function void compare(string name, logic [CountW-1:0] want, logic [CountW-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(trace_res_t got);
      trace_res_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare("irq_pending", CountW'(want.irq_pending), CountW'(got.irq_pending));
      compare("irq_number",  CountW'(want.irq_number),  CountW'(got.irq_number));
      compare("entry_valid", CountW'(want.entry_valid), CountW'(got.entry_valid));
      compare("entry_kind",  CountW'(want.entry_kind),  CountW'(got.entry_kind));
      compare("entry_time",  want.entry_time,  got.entry_time);
      compare("entry_addr",  CountW'(want.entry_addr),  CountW'(got.entry_addr));
      compare("entry_data",  CountW'(want.entry_data),  CountW'(got.entry_data));
      compare("fill_count",  CountW'(want.fill_count),  CountW'(got.fill_count));
      compare("instr_count", want.instr_count, got.instr_count);
      compare("mclk_count",  want.mclk_count,  got.mclk_count);
      compare("smclk_count", want.smclk_count, got.smclk_count);
      compare("aclk_count",  want.aclk_count,  got.aclk_count);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [3:0]        mode_i = '0;
  logic [19:0]       addr_i = '0;
  logic [15:0]       data_i = '0;
  logic [3:0]        irq_i = '0;
  logic [7:0]        mclk_ticks_i = '0;
  logic [7:0]        smclk_ticks_i = '0;
  logic [7:0]        aclk_ticks_i = '0;
  logic              cpu_off_i = 1'b0;
  logic [3:0]        entry_index_i = '0;
  logic              done_o;
  logic              irq_pending_o;
  logic [3:0]        irq_number_o;
  logic              entry_valid_o;
  logic [2:0]        entry_kind_o;
  logic [47:0]       entry_time_o;
  logic [19:0]       entry_addr_o;
  logic [15:0]       entry_data_o;
  logic [3:0]        fill_count_o;
  logic [47:0]       instr_count_o;
  logic [47:0]       mclk_count_o;
  logic [47:0]       smclk_count_o;
  logic [47:0]       aclk_count_o;

  trace_shadow shadow = new();
  int          idle_pct = 0;
  int          stall_cycles = 0;

  io_event_trace_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .addr_i        (addr_i),
    .data_i        (data_i),
    .irq_i         (irq_i),
    .mclk_ticks_i  (mclk_ticks_i),
    .smclk_ticks_i (smclk_ticks_i),
    .aclk_ticks_i  (aclk_ticks_i),
    .cpu_off_i     (cpu_off_i),
    .entry_index_i (entry_index_i),
    .done_o        (done_o),
    .irq_pending_o (irq_pending_o),
    .irq_number_o  (irq_number_o),
    .entry_valid_o (entry_valid_o),
    .entry_kind_o  (entry_kind_o),
    .entry_time_o  (entry_time_o),
    .entry_addr_o  (entry_addr_o),
    .entry_data_o  (entry_data_o),
    .fill_count_o  (fill_count_o),
    .instr_count_o (instr_count_o),
    .mclk_count_o  (mclk_count_o),
    .smclk_count_o (smclk_count_o),
    .aclk_count_o  (aclk_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are sampled at the rising edge, before the block updates them.
  always @(posedge clk_i) begin
    trace_res_t got;
    if (rst_ni && done_o === 1'b1) begin
      got.irq_pending = irq_pending_o;
      got.irq_number  = irq_number_o;
      got.entry_valid = entry_valid_o;
      got.entry_kind  = entry_kind_o;
      got.entry_time  = entry_time_o;
      got.entry_addr  = entry_addr_o;
      got.entry_data  = entry_data_o;
      got.fill_count  = fill_count_o;
      got.instr_count = instr_count_o;
      got.mclk_count  = mclk_count_o;
      got.smclk_count = smclk_count_o;
      got.aclk_count  = aclk_count_o;
      shadow.match_result(got);
    end
  end

  // Watchdog: ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni && !((start && busy === 1'b0) || done_o === 1'b1)) begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("simulation failed");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  // Called at a falling edge; returns at a falling edge after the request is taken.
  task automatic send_request(input trace_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    mode_i        <= r.mode;
    addr_i        <= r.addr;
    data_i        <= r.data;
    irq_i         <= r.irq;
    mclk_ticks_i  <= r.mclk;
    smclk_ticks_i <= r.smclk;
    aclk_ticks_i  <= r.aclk;
    cpu_off_i     <= r.cpu_off;
    entry_index_i <= r.index;
    do @(posedge clk_i); while (busy !== 1'b0);
    shadow.take_request(r);
    @(negedge clk_i);
  endtask

  task automatic issue(input logic [3:0] mode, input logic [19:0] addr, input logic [15:0] data,
                       input logic [3:0] irq, input logic [7:0] ticks, input logic cpu_off,
                       input logic [3:0] index);
    trace_req_t r;
    r.mode = mode;
    r.addr = addr;
    r.data = data;
    r.irq = irq;
    r.mclk = ticks;
    r.smclk = ticks;
    r.aclk = ticks;
    r.cpu_off = cpu_off;
    r.index = index;
    send_request(r);
  endtask

  // Sender holds off until every outstanding result is back.
  task automatic drain();
    start <= 1'b0;
    while (shadow.expected_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_ticks();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hff;
    return 8'($urandom());
  endfunction

  function automatic trace_req_t random_request();
    trace_req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r.addr    = 20'($urandom());
    r.data    = 16'($urandom());
    r.irq     = 4'($urandom());
    r.mclk    = pick_ticks();
    r.smclk   = pick_ticks();
    r.aclk    = pick_ticks();
    r.cpu_off = 1'($urandom());
    r.index   = 4'($urandom());
    if (roll < 40) begin
      r.mode = 4'($urandom_range(MODE_WR_WORD, MODE_RESET));
      // half of the acks name the pending number
      if (r.mode == MODE_IRQ_ACK && $urandom_range(0, 1)) r.irq = shadow.pending_irq();
    end else if (roll < 60) r.mode = MODE_STEP;
    else if (roll < 65) r.mode = MODE_TRIGGER;
    else if (roll < 68) r.mode = MODE_UNTRIG;
    else if (roll < 69) r.mode = MODE_CLEAR;
    else if (roll < 73) r.mode = 4'($urandom_range(11, 15));
    else begin
      r.mode = MODE_READBACK;
      // mostly indexes that hit a held event, some past the fill count
      if ($urandom_range(0, 3) != 0 && shadow.fill() != 0)
        r.index = 4'($urandom_range(0, shadow.fill() - 1));
    end
    return r;
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    int m;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every mode, the corner cases
    issue(MODE_READBACK, '0, '0, '0, '0, 1'b0, 4'd0);            // readback on empty ring
    issue(MODE_STEP, '0, '0, '0, 8'hff, 1'b0, '0);
    issue(MODE_STEP, '0, '0, '0, 8'h00, 1'b1, '0);               // cpu off: no instruction
    issue(MODE_WR_WORD, 20'hfffff, 16'hffff, 4'hf, 8'hff, 1'b1, 4'hf);
    issue(MODE_WR_BYTE, 20'h5a5a5, 16'hffff, '0, '0, 1'b0, '0);   // upper byte dropped
    issue(MODE_RD_WORD, 20'hfffff, 16'hffff, '0, '0, 1'b0, '0);
    issue(MODE_RD_BYTE, 20'h00000, 16'h1234, '0, '0, 1'b0, '0);
    issue(MODE_TRIGGER, '0, '0, 4'd5, '0, 1'b0, '0);
    issue(MODE_IRQ_ACK, '0, '0, 4'd3, '0, 1'b0, '0);             // wrong number, stays pending
    issue(MODE_IRQ_ACK, '0, '0, 4'd5, '0, 1'b0, '0);
    issue(MODE_TRIGGER, '0, '0, 4'hf, '0, 1'b0, '0);
    issue(MODE_TRIGGER, '0, '0, 4'h0, '0, 1'b0, '0);             // replaces request 15
    issue(MODE_RESET, 20'hfffff, 16'hffff, '0, '0, 1'b0, '0);    // logged with zero fields
    issue(MODE_STEP, '0, '0, '0, 8'h80, 1'b0, '0);
    for (m = 11; m <= 15; m++) issue(4'(m), '0, '0, '0, '0, 1'b0, '0);
    issue(MODE_READBACK, '0, '0, '0, '0, 1'b0, 4'd0);
    issue(MODE_READBACK, '0, '0, '0, '0, 1'b0, 4'd6);
    issue(MODE_READBACK, '0, '0, '0, '0, 1'b0, 4'd15);           // beyond fill count
    issue(MODE_UNTRIG, '0, '0, '0, '0, 1'b0, '0);
    issue(MODE_CLEAR, '0, '0, '0, '0, 1'b0, '0);
    issue(MODE_READBACK, '0, '0, '0, '0, 1'b0, 4'd0);
    drain();

    // random: sender idles 35%, then 64%, then never
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 35 : (phase == 1) ? 64 : 0;
      for (n = 0; n < RandomPerPhase; n++) send_request(random_request());
      drain();
    end

    repeat (5) @(posedge clk_i);
    if (shadow.expected_results.size() != 0) begin
      $error("%0d results never arrived", shadow.expected_results.size());
      shadow.mismatches++;
    end
    $display("%0d requests, %0d events read back, %0d oldest events overwritten, %0d clears",
             shadow.requests, shadow.hits, shadow.drops, shadow.clears);
    if (shadow.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
